FILE: rtl/dcm_pkg.sv
// Shared types and constants for the dilated 1D convolution block.
package dcm_pkg;

	localparam int CMD_W = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD_WEIGHT = 2'd0,
		CMD_LOAD_BIAS   = 2'd1,
		CMD_LOAD_SAMPLE = 2'd2,
		CMD_COMPUTE     = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IN_CHANNELS = 3'd0,
		REG_KERNEL      = 3'd1,
		REG_DILATION    = 3'd2,
		REG_STRIDE      = 3'd3,
		REG_PAD_LEFT    = 3'd4,
		REG_PAD_RIGHT   = 3'd5,
		REG_PAD_FILL    = 3'd6,
		REG_FRAME       = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_SATURATED = 2'd1,
		ST_RANGE     = 2'd2
	} status_t;

	localparam int ACC_W = 48;

	// Control from the sequencer to the multiply-accumulate unit.
	typedef struct packed {
		logic clear;
		logic mac;
		logic use_fill;
	} mac_ctrl_t;

endpackage

FILE: rtl/dilated_conv1d_mac.sv
// Top level of the multichannel dilated 1D convolution with a single MAC unit.
//
//  channel   | direction | handshake                | payload
//  ----------+-----------+--------------------------+-------------------------------------
//  request   | in        | start & !busy            | cmd, out_channel, in_channel, tap,
//            |           |                          | position, data_value, bias_value
//  result    | out       | result_valid, one cycle  | result_channel, result_position,
//            |           |                          | result_value, status
//  config    | in        | cfg_we                   | cfg_index, cfg_data
//
// Load requests are stored on acceptance; busy stays low. A compute request walks every
// input channel and tap through one multiplier, one tap a cycle: busy through the
// length and range checks, the taps, the pipeline drain and the done state (taps and
// drain skipped when the position is out of range), result strobed in the cycle after done.
// Reset sets config defaults, clears bias store; weight and sample stores keep data.
// The receiver cannot stall: each result shows for exactly one cycle.
module dilated_conv1d_mac #(
	parameter int MAX_IN_CHANNELS  = 32,
	parameter int MAX_OUT_CHANNELS = 32,
	parameter int MAX_TAPS         = 16,
	parameter int MAX_FRAME        = 512
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     cmd,
	input  logic [4:0]                     out_channel,
	input  logic [4:0]                     in_channel,
	input  logic [3:0]                     tap,
	input  logic [8:0]                     position,
	input  logic signed [15:0]             data_value,
	input  logic signed [31:0]             bias_value,
	input  logic                           cfg_we,
	input  logic [dcm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dcm_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                           result_valid,
	output logic [4:0]                     result_channel,
	output logic [8:0]                     result_position,
	output logic signed [15:0]             result_value,
	output logic [1:0]                     status
);
	import dcm_pkg::*;

	localparam int ICW = (MAX_IN_CHANNELS  > 1) ? $clog2(MAX_IN_CHANNELS)  : 1;
	localparam int OCW = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
	localparam int TW  = (MAX_TAPS  > 1) ? $clog2(MAX_TAPS)  : 1;
	localparam int FW  = $clog2(MAX_FRAME);
	localparam int WDEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_TAPS;
	localparam int SDEPTH = MAX_IN_CHANNELS * MAX_FRAME;
	localparam int WAW = $clog2(WDEPTH);
	localparam int SAW = $clog2(SDEPTH);
	localparam int ICCW = $clog2(MAX_IN_CHANNELS + 1);
	localparam int TCW  = $clog2(MAX_TAPS + 1);
	localparam int PW   = 20;  // signed sample coordinate width

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_LEN   = 6'b000010,
		S_CHECK = 6'b000100,
		S_RUN   = 6'b001000,
		S_DRAIN = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	// ---------------- configuration registers ----------------
	logic [5:0]  nch_q;
	logic [4:0]  kw_q;
	logic [3:0]  dil_q;
	logic [4:0]  str_q;
	logic [7:0]  padl_q, padr_q;
	logic signed [15:0] fill_q;
	logic [9:0]  flen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nch_q <= 6'd1; kw_q <= 5'd1; dil_q <= 4'd1; str_q <= 5'd1;
			padl_q <= '0; padr_q <= '0; fill_q <= '0; flen_q <= 10'd1;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_IN_CHANNELS: nch_q  <= cfg_data[5:0];
				REG_KERNEL:      kw_q   <= cfg_data[4:0];
				REG_DILATION:    dil_q  <= cfg_data[3:0];
				REG_STRIDE:      str_q  <= cfg_data[4:0];
				REG_PAD_LEFT:    padl_q <= cfg_data[7:0];
				REG_PAD_RIGHT:   padr_q <= cfg_data[7:0];
				REG_PAD_FILL:    fill_q <= cfg_data;
				REG_FRAME:       flen_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// Clamped working values.
	logic [ICCW-1:0] nch_c;
	logic [TCW-1:0]  kw_c;
	logic [3:0]      dil_c;
	logic [4:0]      str_c;
	logic [12:0]     flen_c;
	always_comb begin
		nch_c  = (nch_q == 0) ? ICCW'(1) :
			((32'(nch_q) > MAX_IN_CHANNELS) ? ICCW'(MAX_IN_CHANNELS) : ICCW'(nch_q));
		kw_c   = (kw_q == 0) ? TCW'(1) :
			((32'(kw_q) > MAX_TAPS) ? TCW'(MAX_TAPS) : TCW'(kw_q));
		dil_c  = (dil_q == 0) ? 4'd1 : dil_q;
		str_c  = (str_q == 0) ? 5'd1 : str_q;
		flen_c = (flen_q == 0) ? 13'd1 :
			((32'(flen_q) > MAX_FRAME) ? 13'(MAX_FRAME) : 13'(flen_q));
	end

	// ---------------- stores ----------------
	logic signed [15:0] weight_mem [WDEPTH];
	logic signed [15:0] sample_mem [SDEPTH];
	logic signed [31:0] bias_q [MAX_OUT_CHANNELS];

	logic accept;
	assign accept = start && !busy;

	logic w_ok, s_ok, b_ok;
	assign w_ok = 32'(out_channel) < MAX_OUT_CHANNELS && 32'(in_channel) < MAX_IN_CHANNELS
		&& 32'(tap) < MAX_TAPS;
	assign s_ok = 32'(in_channel) < MAX_IN_CHANNELS && 32'(position) < MAX_FRAME;
	assign b_ok = 32'(out_channel) < MAX_OUT_CHANNELS;

	logic [WAW-1:0] w_waddr, w_raddr;
	logic [SAW-1:0] s_waddr, s_raddr;
	assign w_waddr = WAW'((32'(out_channel) * MAX_IN_CHANNELS + 32'(in_channel)) * MAX_TAPS
		+ 32'(tap));
	assign s_waddr = SAW'(32'(in_channel) * MAX_FRAME + 32'(position));

	logic signed [15:0] w_rd_s1, s_rd_s1;
	always_ff @(posedge clk) begin
		if (accept && cmd_t'(cmd) == CMD_LOAD_WEIGHT && w_ok) begin
			weight_mem[w_waddr] <= data_value;
		end
		if (accept && cmd_t'(cmd) == CMD_LOAD_SAMPLE && s_ok) begin
			sample_mem[s_waddr] <= data_value;
		end
		w_rd_s1 <= weight_mem[w_raddr];
		s_rd_s1 <= sample_mem[s_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_OUT_CHANNELS; i++) bias_q[i] <= '0;
		end else if (accept && cmd_t'(cmd) == CMD_LOAD_BIAS && b_ok) begin
			bias_q[OCW'(out_channel)] <= bias_value;
		end
	end

	// ---------------- sequencer ----------------
	state_t state_q;
	logic [OCW-1:0] oc_q;
	logic [4:0]  oc_raw_q;
	logic [8:0]  pos_q;
	logic [ICCW-1:0] c_q;
	logic [TCW-1:0]  k_q;
	logic signed [PW-1:0] base_q;   // pos*stride - padl
	logic signed [PW-1:0] r_q;      // current sample coordinate
	logic [14:0] span_q;            // padded width minus extent
	logic        short_q;           // padded width below extent
	logic [14:0] plim_q;            // pos*stride
	logic [2:0]  drain_q;
	logic        range_err_q;
	logic        pad_s1;

	logic last_tap, last_ch;
	assign last_tap = (k_q == kw_c - TCW'(1));
	assign last_ch  = (c_q == nch_c - ICCW'(1));

	assign w_raddr = WAW'((32'(oc_q) * MAX_IN_CHANNELS + 32'(c_q[ICW-1:0])) * MAX_TAPS
		+ 32'(k_q[TW-1:0]));
	assign s_raddr = SAW'(32'(c_q[ICW-1:0]) * MAX_FRAME + 32'(r_q[FW-1:0]));

	mac_ctrl_t ctrl;
	logic signed [15:0] mac_value;
	logic mac_sat;
	logic run_tap;
	assign run_tap = (state_q == S_RUN);

	always_comb begin
		ctrl.clear    = (state_q == S_CHECK);
		ctrl.mac      = 1'b0;
		ctrl.use_fill = pad_s1;
	end

	// Read data lands in the cycle after the address; the product is registered after that.
	logic mac_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mac_s1 <= 1'b0;
		else mac_s1 <= run_tap;
	end
	mac_ctrl_t ctrl_d;
	always_comb begin
		ctrl_d = ctrl;
		ctrl_d.mac = mac_s1;
	end

	always_ff @(posedge clk) begin
		pad_s1 <= (r_q < 0) || (r_q >= PW'(flen_c));
	end

	dcm_mac_unit u_mac (
		.clk       (clk),
		.ctrl      (ctrl_d),
		.bias      (bias_q[oc_q]),
		.sample    (s_rd_s1),
		.fill      (fill_q),
		.weight    (w_rd_s1),
		.value     (mac_value),
		.saturated (mac_sat)
	);

	// Range: pos < outlen  <=>  W >= E and pos*stride <= W - E.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (accept && cmd_t'(cmd) == CMD_COMPUTE) state_q <= S_LEN;
				S_LEN: state_q <= S_CHECK;
				S_CHECK: state_q <= range_err_q ? S_DONE : S_RUN;
				S_RUN: if (last_tap && last_ch) state_q <= S_DRAIN;
				S_DRAIN: if (drain_q == 3'd0) state_q <= S_DONE;
				S_DONE: begin
					state_q <= S_IDLE;
					result_valid <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	logic [14:0] wide_w, ext_w;
	assign wide_w = 15'(flen_c) + 15'(padl_q) + 15'(padr_q);
	assign ext_w  = 15'(dil_c) * 15'(kw_c - TCW'(1)) + 15'd1;

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				oc_raw_q <= out_channel;
				oc_q     <= OCW'(out_channel);
				pos_q    <= position;
				plim_q   <= 15'(position) * 15'(str_c);
				short_q  <= wide_w < ext_w;
				span_q   <= wide_w - ext_w;
			end
			S_LEN: begin
				range_err_q <= short_q || (plim_q > span_q)
					|| (32'(oc_raw_q) >= MAX_OUT_CHANNELS);
				base_q <= PW'(plim_q) - PW'(padl_q);
			end
			S_CHECK: begin
				c_q <= '0; k_q <= '0; r_q <= base_q; drain_q <= 3'd3;
			end
			S_RUN: begin
				if (last_tap) begin
					k_q <= '0; c_q <= c_q + ICCW'(1); r_q <= base_q;
				end else begin
					k_q <= k_q + TCW'(1); r_q <= r_q + PW'(dil_c);
				end
			end
			S_DRAIN: drain_q <= drain_q - 3'd1;
			S_DONE: begin
				result_channel  <= oc_raw_q;
				result_position <= pos_q;
				result_value    <= range_err_q ? 16'sd0 : mac_value;
				status          <= range_err_q ? ST_RANGE : (mac_sat ? ST_SATURATED : ST_OK);
			end
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

FILE: rtl/dcm_mac_unit.sv
// Shared multiply-accumulate unit with registered product and output rounding.
module dcm_mac_unit (
	input  logic                      clk,
	input  dcm_pkg::mac_ctrl_t        ctrl,
	input  logic signed [31:0]        bias,
	input  logic signed [15:0]        sample,
	input  logic signed [15:0]        fill,
	input  logic signed [15:0]        weight,
	output logic signed [15:0]        value,
	output logic                      saturated
);
	import dcm_pkg::*;

	logic signed [31:0]      prod_s1;
	logic                    prod_vld_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] rnd;
	logic signed [ACC_W-16:0] q;

	always_ff @(posedge clk) begin
		prod_s1     <= (ctrl.use_fill ? fill : sample) * weight;
		prod_vld_s1 <= ctrl.mac;
		if (ctrl.clear) begin
			acc_q <= ACC_W'(bias);
		end else if (prod_vld_s1) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
	end

	// Round half up, then arithmetic shift by 15 (floor).
	always_comb begin
		rnd = acc_q + ACC_W'(16384);
		q   = rnd[ACC_W-1:15];
		saturated = 1'b0;
		value = q[15:0];
		if (q > 32767) begin
			value = 16'sh7fff;
			saturated = 1'b1;
		end else if (q < -32768) begin
			value = 16'sh8000;
			saturated = 1'b1;
		end
	end
endmodule

FILE: rtl/dilated_conv1d_mac_checker.sv
// Port-level checker for the convolution block, bound to the top level.
module dilated_conv1d_mac_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] cmd,
	input logic       result_valid,
	input logic [1:0] status
);
	import dcm_pkg::*;

	a_load_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd != CMD_COMPUTE |=> !busy) else $error("load held block busy");
	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd == CMD_COMPUTE |=> busy) else $error("compute did not start");
	a_result_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("result held two cycles");
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy) else $error("result while busy");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> status != 2'd3) else $error("bad status");
endmodule

bind dilated_conv1d_mac dilated_conv1d_mac_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
	.result_valid(result_valid), .status(status)
);
